/* sv/hpts_pkg.sv */
// Package for the half-period trainer/sync unit: widths, reset values, config indices, phase codes, channel structs.
// No dependencies.
package hpts_pkg;
    localparam int TRAINING_DEPTH_DEF = 16;
    localparam logic [9:0]  THRESH_RST = 10'd716;
    localparam logic [15:0] HMIN_RST = 16'h1000;
    localparam logic [15:0] HMAX_RST = 16'h3000;
    localparam logic [15:0] LMIN_RST = 16'h7000;
    localparam logic [15:0] LMAX_RST = 16'h9000;
    localparam logic [15:0] TIMER_MAX = 16'hffff;
    localparam logic [2:0] CFG_THRESH = 3'd0;
    localparam logic [2:0] CFG_HMIN = 3'd1;
    localparam logic [2:0] CFG_HMAX = 3'd2;
    localparam logic [2:0] CFG_LMIN = 3'd3;
    localparam logic [2:0] CFG_LMAX = 3'd4;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRAIN = 2'd1;
    localparam logic [1:0] PH_SYNC = 2'd2;
    typedef struct packed {
        logic [9:0] sample;
        logic [9:0] ticks_elapsed;
    } in_item_t;
    typedef struct packed {
        logic [1:0]  phase;
        logic        level;
        logic        edge_res;
        logic [15:0] high_length;
        logic [15:0] low_length;
        logic        sync_loaded;
        logic        timer_wrapped;
    } out_item_t;
    typedef struct packed {
        logic        start;
        logic [15:0] lo;
        logic [15:0] hi;
    } tm_req_t;
endpackage

/* sv/hpts_if.sv */
// Valid/ready channel interfaces for the trainer/sync unit.
// Depends on hpts_pkg.
interface hpts_in_if;
    logic valid;
    logic ready;
    hpts_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hpts_out_if;
    logic valid;
    logic ready;
    hpts_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/half_period_trainer_sync_unit.sv */
// Half-period trainer and sync unit.
// Request in: sample + ticks_elapsed; one result request out per input.
// Configuration by index/data write port; the user must write it only while idle (not enforced).
// An item without a completing training edge passes through S_IN, S_WAIT and S_OUT.
// The edge that fills a training store runs the trimmed mean:
// two passes over the store memory, one entry read per cycle, while the
// item waits in S_WAIT before its result goes to the output register.
// One item is in flight at a time; the result sits in an output register
// until taken, and in.ready is low until it is taken.
// Reset clears phase, level, timer, counts and averages and loads the
// register reset values. Store contents are undefined until written.
// Receiver stall holds the result and blocks further input.
module half_period_trainer_sync_unit #(
    parameter int TRAINING_DEPTH = hpts_pkg::TRAINING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hpts_in_if.sink     in_ch,
    hpts_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int AW = $clog2(TRAINING_DEPTH);

    typedef enum logic [1:0] {S_IN, S_WAIT, S_OUT} state_t;

    logic [9:0]  thresh_reg;
    logic [15:0] hmin_reg, hmax_reg, lmin_reg, lmax_reg;
    state_t      state_reg;
    logic [1:0]  phase_reg;
    logic        level_reg, running_reg;
    logic [15:0] timer_reg, havg_reg, lavg_reg;
    logic [AW:0] hcnt_reg, lcnt_reg;
    logic [14:0] offs_reg;
    logic        wait_h_reg, wait_l_reg;
    logic        edge_reg, loaded_reg, wrap_reg;
    hpts_pkg::out_item_t out_reg;

    logic [16:0] tsum;
    logic [15:0] tnow;
    logic        lvl, edg, hwr, lwr, hlast, llast;
    hpts_pkg::tm_req_t hreq, lreq;
    logic        hdone, ldone;
    logic [15:0] hres, lres;
    logic [AW:0] hcnt_n, lcnt_n;

    assign tsum = {1'b0, timer_reg} + 17'(in_ch.data.ticks_elapsed);
    assign tnow = running_reg ? tsum[15:0] : timer_reg;
    assign lvl = in_ch.data.sample > thresh_reg;
    assign edg = lvl != level_reg;
    assign hwr = in_ch.valid && state_reg == S_IN && edg && phase_reg == hpts_pkg::PH_TRAIN
                 && !lvl && hcnt_reg != (AW+1)'(TRAINING_DEPTH);
    assign lwr = in_ch.valid && state_reg == S_IN && edg && phase_reg == hpts_pkg::PH_TRAIN
                 && lvl && lcnt_reg != (AW+1)'(TRAINING_DEPTH);
    assign hlast = hcnt_reg == (AW+1)'(TRAINING_DEPTH - 1);
    assign llast = lcnt_reg == (AW+1)'(TRAINING_DEPTH - 1);
    assign hcnt_n = hcnt_reg + (AW+1)'(hwr);
    assign lcnt_n = lcnt_reg + (AW+1)'(lwr);
    assign hreq = '{start: hwr && hlast, lo: hmin_reg, hi: hmax_reg};
    assign lreq = '{start: lwr && llast, lo: lmin_reg, hi: lmax_reg};

    hpts_store #(.DEPTH(TRAINING_DEPTH)) u_hstore (
        .clk(clk), .rst_n(rst_n), .wr_en(hwr), .wr_addr(hcnt_reg[AW-1:0]),
        .wr_data(tnow), .req(hreq), .done(hdone), .avg(hres));
    hpts_store #(.DEPTH(TRAINING_DEPTH)) u_lstore (
        .clk(clk), .rst_n(rst_n), .wr_en(lwr), .wr_addr(lcnt_reg[AW-1:0]),
        .wr_data(tnow), .req(lreq), .done(ldone), .avg(lres));

    assign in_ch.ready = state_reg == S_IN;
    assign out_ch.valid = state_reg == S_OUT;
    assign out_ch.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= hpts_pkg::THRESH_RST;
            hmin_reg <= hpts_pkg::HMIN_RST;
            hmax_reg <= hpts_pkg::HMAX_RST;
            lmin_reg <= hpts_pkg::LMIN_RST;
            lmax_reg <= hpts_pkg::LMAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpts_pkg::CFG_THRESH: thresh_reg <= cfg_data[9:0];
                hpts_pkg::CFG_HMIN: hmin_reg <= cfg_data;
                hpts_pkg::CFG_HMAX: hmax_reg <= cfg_data;
                hpts_pkg::CFG_LMIN: lmin_reg <= cfg_data;
                hpts_pkg::CFG_LMAX: lmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            phase_reg <= hpts_pkg::PH_IDLE;
            level_reg <= 1'b0;
            running_reg <= 1'b0;
            timer_reg <= '0;
            havg_reg <= '0;
            lavg_reg <= '0;
            hcnt_reg <= '0;
            lcnt_reg <= '0;
            offs_reg <= '0;
            wait_h_reg <= 1'b0;
            wait_l_reg <= 1'b0;
            edge_reg <= 1'b0;
            loaded_reg <= 1'b0;
            wrap_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IN:
                begin
                    if (in_ch.valid)
                    begin
                        edge_reg <= edg;
                        wrap_reg <= running_reg && tsum[16];
                        loaded_reg <= 1'b0;
                        timer_reg <= tnow;
                        wait_h_reg <= hwr && hlast;
                        wait_l_reg <= lwr && llast;
                        hcnt_reg <= hcnt_n;
                        lcnt_reg <= lcnt_n;
                        if (hwr)
                            havg_reg <= tnow;
                        if (lwr)
                            lavg_reg <= tnow;
                        if (edg)
                        begin
                            level_reg <= lvl;
                            if (phase_reg == hpts_pkg::PH_SYNC && !lvl)
                            begin
                                timer_reg <= hpts_pkg::TIMER_MAX - {1'b0, offs_reg};
                                running_reg <= 1'b1;
                                loaded_reg <= 1'b1;
                            end
                            else if (phase_reg == hpts_pkg::PH_IDLE)
                            begin
                                timer_reg <= '0;
                                running_reg <= 1'b1;
                                phase_reg <= hpts_pkg::PH_TRAIN;
                            end
                            else if (phase_reg == hpts_pkg::PH_TRAIN)
                                timer_reg <= '0;
                        end
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (hdone)
                    begin
                        havg_reg <= hres;
                        wait_h_reg <= 1'b0;
                    end
                    if (ldone)
                    begin
                        lavg_reg <= lres;
                        wait_l_reg <= 1'b0;
                    end
                    if (!wait_h_reg && !wait_l_reg)
                    begin
                        if (phase_reg == hpts_pkg::PH_TRAIN && edge_reg
                            && hcnt_reg == (AW+1)'(TRAINING_DEPTH)
                            && lcnt_reg == (AW+1)'(TRAINING_DEPTH))
                        begin
                            phase_reg <= hpts_pkg::PH_SYNC;
                            running_reg <= 1'b0;
                            timer_reg <= '0;
                            offs_reg <= lavg_reg[15:1];
                            out_reg.phase <= hpts_pkg::PH_SYNC;
                        end
                        else
                            out_reg.phase <= phase_reg;
                        out_reg.level <= level_reg;
                        out_reg.edge_res <= edge_reg;
                        out_reg.high_length <= havg_reg;
                        out_reg.low_length <= lavg_reg;
                        out_reg.sync_loaded <= loaded_reg;
                        out_reg.timer_wrapped <= wrap_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IN;
                end
                default: state_reg <= S_IN;
            endcase
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while item in flight");
    a_no_phase_back: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(phase_reg) == hpts_pkg::PH_SYNC) |-> (phase_reg == hpts_pkg::PH_SYNC))
        else $error("phase left sync mode");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (hcnt_reg <= (AW+1)'(TRAINING_DEPTH)) && (lcnt_reg <= (AW+1)'(TRAINING_DEPTH)))
        else $error("training count overflow");
endmodule

/* sv/hpts_store.sv */
// Training store memory with trimmed-mean sequencer (two passes over the entries).
// Depends on hpts_pkg.
module hpts_store #(
    parameter int DEPTH = hpts_pkg::TRAINING_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [15:0]              wr_data,
    input  hpts_pkg::tm_req_t        req,
    output logic                     done,
    output logic [15:0]              avg
);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = 16 + AW + 1;

    typedef enum logic [1:0] {S_IDLE, S_P1, S_P2, S_FIN} state_t;

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;
    state_t      state_reg;
    logic [AW:0] idx_reg;
    logic        rv_reg;
    logic [AW-1:0] ridx_reg;
    logic        any_reg;
    logic [15:0] maxv_reg, minv_reg, last_reg, lo_reg, hi_reg;
    logic [AW-1:0] maxi_reg, mini_reg;
    logic [AW:0] drop_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] pad;
    logic        vok;

    assign vok = !(rd_data_reg < lo_reg || rd_data_reg > hi_reg);
    assign pad = SW'(drop_reg) * SW'(last_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            rv_reg <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    rv_reg <= 1'b0;
                    if (req.start)
                    begin
                        state_reg <= S_P1;
                        idx_reg <= '0;
                        any_reg <= 1'b0;
                        lo_reg <= req.lo;
                        hi_reg <= req.hi;
                    end
                end
                S_P1, S_P2:
                begin
                    if (idx_reg != (AW+1)'(DEPTH))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        rv_reg <= 1'b1;
                        ridx_reg <= idx_reg[AW-1:0];
                    end
                    else
                        rv_reg <= 1'b0;
                    if (rv_reg && state_reg == S_P1 && vok)
                    begin
                        if (!any_reg || rd_data_reg > maxv_reg)
                        begin
                            maxv_reg <= rd_data_reg;
                            maxi_reg <= ridx_reg;
                        end
                        if (!any_reg || rd_data_reg < minv_reg)
                        begin
                            minv_reg <= rd_data_reg;
                            mini_reg <= ridx_reg;
                        end
                        any_reg <= 1'b1;
                        last_reg <= rd_data_reg;
                    end
                    if (rv_reg && state_reg == S_P2)
                    begin
                        if (!vok || ridx_reg == maxi_reg || ridx_reg == mini_reg)
                            drop_reg <= drop_reg + 1'b1;
                        else
                            sum_reg <= sum_reg + SW'(rd_data_reg);
                    end
                    if (rv_reg && ridx_reg == AW'(DEPTH - 1))
                    begin
                        rv_reg <= 1'b0;
                        if (state_reg == S_P1)
                        begin
                            state_reg <= S_P2;
                            idx_reg <= '0;
                            drop_reg <= '0;
                            sum_reg <= '0;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!any_reg)
                        avg <= '0;
                    else
                        avg <= 16'((sum_reg + pad) >> AW);
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
